### rtl/sqat_pkg.sv
// ---------------------------------------------------------------------------
// Send queue package
// Shared widths, codes and record types for the send queue and its cells.
// ---------------------------------------------------------------------------
`default_nettype none

package sqat_pkg;

   // Queue size default for the top level parameter
   localparam int QUEUE_DEPTH_DEFAULT = 32;

   // Field widths
   localparam int DEV_W     = 32;
   localparam int OFF_W     = 64;
   localparam int HASH_W    = 64;
   localparam int LEN_W     = 16;
   localparam int LIMIT_W   = 6;
   localparam int BPD_W     = 6;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 5;
   localparam int OCC_W     = 6;
   localparam int CMD_W     = 2;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_DATA_W = 184;
   localparam int RSP_DATA_W = 192;

   // Most results a list transaction may report
   localparam logic [LIMIT_W-1:0] MAX_RESULTS = 6'd32;

   // Register reset values
   localparam logic [BPD_W-1:0] BPD_RESET     = 6'd24;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd4096;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_ACK  = 2'd2,
      CMD_LIST = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 3'd0,
      STS_PUSHED_BP = 3'd1,
      STS_TOO_LARGE = 3'd2,
      STS_FULL      = 3'd3,
      STS_EMPTY     = 3'd4,
      STS_NONE      = 3'd5,
      STS_RSVD6     = 3'd6,
      STS_RSVD7     = 3'd7
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BP_DEPTH = 1'd0,
      CSR_MAX_LEN  = 1'd1
   } csr_idx_type;

   // One stored descriptor
   typedef struct packed {
      logic [DEV_W-1:0]  dev;
      logic [OFF_W-1:0]  off;
      logic [HASH_W-1:0] hash;
      logic [LEN_W-1:0]  len;
      logic              pending;
   } entry_type;

   // Broadcast control from the sequencer to every cell
   typedef struct packed {
      logic             token_start;
      logic             token_shift;
      logic             clr_pend;
      logic             match_ack;
      logic [DEV_W-1:0] key_dev;
      logic [OFF_W-1:0] key_off;
   } cell_ctrl_type;

   // One result transaction
   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [DEV_W-1:0]  dev;
      logic [OFF_W-1:0]  off;
      logic [HASH_W-1:0] hash;
      logic [LEN_W-1:0]  len;
      logic              pend;
      logic [OCC_W-1:0]  occ;
      logic              bp;
      logic              last;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/sqat_cell.sv
// ---------------------------------------------------------------------------
// Send queue cell
// Holds one descriptor slot and one bit of the scan token that walks the row.
// ---------------------------------------------------------------------------
`default_nettype none

module sqat_cell #(
   parameter bit FIRST = 1'b0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sqat_pkg::cell_ctrl_type ctrl,
   input  logic                    wr_sel,
   input  sqat_pkg::entry_type     wr_data,
   input  logic                    token_prev,
   output logic                    token_out,
   output sqat_pkg::entry_type     entry_out,
   output logic                    hit
);
   import sqat_pkg::*;

   logic [DEV_W-1:0]  dev_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [HASH_W-1:0] hash_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              pend_ff, pend_in;
   logic              token_ff, token_in;

   // Descriptor payload, written on push
   always_ff @(posedge clock) begin
      if (wr_sel) begin
         dev_ff  <= wr_data.dev;
         off_ff  <= wr_data.off;
         hash_ff <= wr_data.hash;
         len_ff  <= wr_data.len;
      end
   end

   // Pending mark: set by push, cleared by a matching ack under the token
   always_comb begin
      pend_in = pend_ff;
      if (wr_sel) begin
         pend_in = 1'b1;
      end else if (ctrl.clr_pend && token_ff) begin
         pend_in = 1'b0;
      end
   end

   // Token: loaded at cell 0, then handed to the next cell
   always_comb begin
      token_in = token_ff;
      if (ctrl.token_start) begin
         token_in = FIRST;
      end else if (ctrl.token_shift) begin
         token_in = token_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         token_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         token_ff <= token_in;
      end
   end

   assign token_out = token_ff;
   assign entry_out = '{dev: dev_ff, off: off_ff, hash: hash_ff, len: len_ff,
                        pending: pend_ff};
   // Hit: token here, pending, and on ack the key matches
   assign hit = token_ff && pend_ff &&
                (!ctrl.match_ack || (dev_ff == ctrl.key_dev && off_ff == ctrl.key_off));

endmodule

`default_nettype wire

### rtl/send_queue_with_ack_tracking_unit.sv
// ---------------------------------------------------------------------------
// Send queue with acknowledge tracking
// Ring of descriptor cells with pending marks; push, pop, ack and list.
// ---------------------------------------------------------------------------
//  Channel  | Signals                            | Content
//  req      | req_tvalid/tready/tdata/tuser      | command in tuser, descriptor
//  rsp      | rsp_tvalid/tready/tdata/tuser/tlast| status in tuser, entry data
//  csr      | csr_wr_en/csr_index/csr_wdata      | register writes, no read-back
//
//  Push and pop are handled directly from idle; the result is registered.
//  Ack and list walk a token through the cells, one cell per cycle unless
//  a found entry waits on a stalled rsp, which holds the scan in place;
//  req is taken only when idle.
//  Synchronous reset clears pointers, count, marks and the sequencer;
//  no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module send_queue_with_ack_tracking_unit #(
   parameter int QUEUE_DEPTH = sqat_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // device_number, byte_offset, hash_value, payload_length, list_limit
   input  logic [sqat_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command
   input  logic [sqat_pkg::CMD_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // slot_index, entry_device, entry_offset, entry_hash, entry_length,
   // entry_pending, occupancy, backpressure_flag
   output logic [sqat_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status
   output logic [sqat_pkg::STATUS_W-1:0]    rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_wr_en,
   input  logic [sqat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sqat_pkg::CSR_W-1:0]       csr_wdata
);
   import sqat_pkg::*;

   localparam int IW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int CMPW = (CW > BPD_W) ? CW : BPD_W;
   localparam logic [IW-1:0] LAST_IDX  = IW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      FSM_IDLE  = 3'b001,
      FSM_SCAN  = 3'b010,
      FSM_FLUSH = 3'b100
   } fsm_type;

   // Request fields
   cmd_type             req_cmd;
   logic [DEV_W-1:0]    req_dev;
   logic [OFF_W-1:0]    req_off;
   logic [HASH_W-1:0]   req_hash;
   logic [LEN_W-1:0]    req_len;
   logic [LIMIT_W-1:0]  req_limit;

   assign req_cmd   = cmd_type'(req_tuser);
   assign req_dev   = req_tdata[31:0];
   assign req_off   = req_tdata[95:32];
   assign req_hash  = req_tdata[159:96];
   assign req_len   = req_tdata[175:160];
   assign req_limit = req_tdata[181:176];

   // State
   fsm_type             fsm_ff, fsm_in;
   logic [IW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                bp_ff, bp_in;
   logic [BPD_W-1:0]    bpd_ff;
   logic [LEN_W-1:0]    max_len_ff;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                ack_mode_ff, ack_mode_in;
   logic [DEV_W-1:0]    key_dev_ff, key_dev_in;
   logic [OFF_W-1:0]    key_off_ff, key_off_in;
   logic [LIMIT_W-1:0]  cap_ff, cap_in;
   logic [LIMIT_W-1:0]  n_ff, n_in;
   logic                hold_valid_ff, hold_valid_in;
   logic [IW-1:0]       hold_slot_ff, hold_slot_in;
   logic [DEV_W-1:0]    hold_dev_ff, hold_dev_in;
   logic [OFF_W-1:0]    hold_off_ff, hold_off_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff, out_in;

   // Cell row
   cell_ctrl_type           ctrl;
   entry_type               cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]  cell_hit;
   logic [QUEUE_DEPTH-1:0]  cell_token;
   logic [QUEUE_DEPTH-1:0]  wr_sel;
   logic                    push_ok;
   entry_type               wr_data;

   logic        out_free;
   logic        req_acc;
   logic        hit_any;
   entry_type   sel_entry;
   entry_type   pop_entry;
   logic [CW-1:0]   cnt_inc, cnt_dec;
   logic [CMPW-1:0] bpd_ext;
   logic            bp_new;

   function automatic rsp_type mk_rsp(input status_type sts, input logic [SLOT_W-1:0] slot,
                                      input logic [DEV_W-1:0] dev,
                                      input logic [OFF_W-1:0] off,
                                      input logic [HASH_W-1:0] hash,
                                      input logic [LEN_W-1:0] len, input logic pend,
                                      input logic [OCC_W-1:0] occ, input logic bp,
                                      input logic last);
      rsp_type r;
      r.status = sts;
      r.slot   = slot;
      r.dev    = dev;
      r.off    = off;
      r.hash   = hash;
      r.len    = len;
      r.pend   = pend;
      r.occ    = occ;
      r.bp     = bp;
      r.last   = last;
      return r;
   endfunction

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (fsm_ff == FSM_IDLE) && out_free;
   assign req_acc    = req_tvalid && req_tready;
   assign hit_any    = |cell_hit;
   assign sel_entry  = cell_entry[idx_ff];
   assign pop_entry  = cell_entry[rd_ptr_ff];
   assign cnt_inc    = cnt_ff + CW'(1);
   assign cnt_dec    = cnt_ff - CW'(1);
   assign bpd_ext    = CMPW'(bpd_ff);
   assign wr_data    = '{dev: req_dev, off: req_off, hash: req_hash, len: req_len,
                         pending: 1'b1};

   // Cells
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign wr_sel[i] = push_ok && (wr_ptr_ff == IW'(i));
      sqat_cell #(.FIRST(i == 0)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .wr_sel     (wr_sel[i]),
         .wr_data    (wr_data),
         .token_prev ((i == 0) ? 1'b0 : cell_token[(i == 0) ? 0 : i - 1]),
         .token_out  (cell_token[i]),
         .entry_out  (cell_entry[i]),
         .hit        (cell_hit[i])
      );
   end

   // Sequencer
   always_comb begin
      fsm_in        = fsm_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      cnt_in        = cnt_ff;
      bp_in         = bp_ff;
      idx_in        = idx_ff;
      ack_mode_in   = ack_mode_ff;
      key_dev_in    = key_dev_ff;
      key_off_in    = key_off_ff;
      cap_in        = cap_ff;
      n_in          = n_ff;
      hold_valid_in = hold_valid_ff;
      hold_slot_in  = hold_slot_ff;
      hold_dev_in   = hold_dev_ff;
      hold_off_in   = hold_off_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_in        = out_ff;
      push_ok       = 1'b0;
      bp_new        = bp_ff;
      ctrl.token_start = 1'b0;
      ctrl.token_shift = 1'b0;
      ctrl.clr_pend    = 1'b0;
      ctrl.match_ack   = ack_mode_ff;
      ctrl.key_dev     = key_dev_ff;
      ctrl.key_off     = key_off_ff;

      unique case (fsm_ff)
         FSM_IDLE: begin
            if (req_acc) begin
               unique case (req_cmd)
                  CMD_PUSH: begin
                     out_valid_in = 1'b1;
                     if (req_len > max_len_ff) begin
                        out_in = mk_rsp(STS_TOO_LARGE, '0, '0, '0, '0, '0, 1'b0,
                                        OCC_W'(cnt_ff), bp_ff, 1'b1);
                     end else if (cnt_ff >= DEPTH_CNT) begin
                        out_in = mk_rsp(STS_FULL, '0, '0, '0, '0, '0, 1'b0,
                                        OCC_W'(cnt_ff), bp_ff, 1'b1);
                     end else begin
                        push_ok   = 1'b1;
                        wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + IW'(1);
                        cnt_in    = cnt_inc;
                        bp_new    = bp_ff || (CMPW'(cnt_inc) >= bpd_ext);
                        bp_in     = bp_new;
                        out_in    = mk_rsp(bp_new ? STS_PUSHED_BP : STS_OK,
                                           SLOT_W'(wr_ptr_ff), '0, '0, '0, '0, 1'b0,
                                           OCC_W'(cnt_inc), bp_new, 1'b1);
                     end
                  end
                  CMD_POP: begin
                     out_valid_in = 1'b1;
                     if (cnt_ff == '0) begin
                        out_in = mk_rsp(STS_EMPTY, '0, '0, '0, '0, '0, 1'b0,
                                        OCC_W'(cnt_ff), bp_ff, 1'b1);
                     end else begin
                        rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + IW'(1);
                        cnt_in    = cnt_dec;
                        bp_new    = bp_ff && !(CMPW'(cnt_dec) < bpd_ext);
                        bp_in     = bp_new;
                        out_in    = mk_rsp(STS_OK, SLOT_W'(rd_ptr_ff), pop_entry.dev,
                                           pop_entry.off, pop_entry.hash, pop_entry.len,
                                           pop_entry.pending, OCC_W'(cnt_dec), bp_new,
                                           1'b1);
                     end
                  end
                  CMD_ACK: begin
                     ack_mode_in      = 1'b1;
                     key_dev_in       = req_dev;
                     key_off_in       = req_off;
                     idx_in           = '0;
                     ctrl.token_start = 1'b1;
                     fsm_in           = FSM_SCAN;
                  end
                  CMD_LIST: begin
                     ack_mode_in   = 1'b0;
                     cap_in        = (req_limit > MAX_RESULTS) ? MAX_RESULTS : req_limit;
                     n_in          = '0;
                     hold_valid_in = 1'b0;
                     idx_in        = '0;
                     if (req_limit == '0) begin
                        fsm_in = FSM_FLUSH;
                     end else begin
                        ctrl.token_start = 1'b1;
                        fsm_in           = FSM_SCAN;
                     end
                  end
               endcase
            end
         end

         FSM_SCAN: begin
            if (ack_mode_ff) begin
               // Ack: stop at the first pending match
               if (hit_any) begin
                  if (out_free) begin
                     ctrl.clr_pend = 1'b1;
                     out_valid_in  = 1'b1;
                     out_in = mk_rsp(STS_OK, SLOT_W'(idx_ff), '0, '0, '0, '0, 1'b0,
                                     OCC_W'(cnt_ff), bp_ff, 1'b1);
                     fsm_in = FSM_IDLE;
                  end
               end else if (idx_ff == LAST_IDX) begin
                  if (out_free) begin
                     out_valid_in = 1'b1;
                     out_in = mk_rsp(STS_NONE, '0, '0, '0, '0, '0, 1'b0,
                                     OCC_W'(cnt_ff), bp_ff, 1'b1);
                     fsm_in = FSM_IDLE;
                  end
               end else begin
                  ctrl.token_shift = 1'b1;
                  idx_in           = idx_ff + IW'(1);
               end
            end else begin
               // List: keep one found entry back so the final one gets last
               if (hit_any) begin
                  if (!hold_valid_ff || out_free) begin
                     if (hold_valid_ff) begin
                        out_valid_in = 1'b1;
                        out_in = mk_rsp(STS_OK, SLOT_W'(hold_slot_ff), hold_dev_ff,
                                        hold_off_ff, '0, '0, 1'b1, OCC_W'(cnt_ff),
                                        bp_ff, 1'b0);
                     end
                     hold_valid_in = 1'b1;
                     hold_slot_in  = idx_ff;
                     hold_dev_in   = sel_entry.dev;
                     hold_off_in   = sel_entry.off;
                     n_in          = n_ff + LIMIT_W'(1);
                     if ((n_ff + LIMIT_W'(1)) == cap_ff || idx_ff == LAST_IDX) begin
                        fsm_in = FSM_FLUSH;
                     end else begin
                        ctrl.token_shift = 1'b1;
                        idx_in           = idx_ff + IW'(1);
                     end
                  end
               end else if (idx_ff == LAST_IDX) begin
                  fsm_in = FSM_FLUSH;
               end else begin
                  ctrl.token_shift = 1'b1;
                  idx_in           = idx_ff + IW'(1);
               end
            end
         end

         FSM_FLUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (hold_valid_ff) begin
                  out_in = mk_rsp(STS_OK, SLOT_W'(hold_slot_ff), hold_dev_ff, hold_off_ff,
                                  '0, '0, 1'b1, OCC_W'(cnt_ff), bp_ff, 1'b1);
               end else begin
                  out_in = mk_rsp(STS_NONE, '0, '0, '0, '0, '0, 1'b0,
                                  OCC_W'(cnt_ff), bp_ff, 1'b1);
               end
               hold_valid_in = 1'b0;
               fsm_in        = FSM_IDLE;
            end
         end

         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= FSM_IDLE;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         cnt_ff        <= '0;
         bp_ff         <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         ack_mode_ff   <= 1'b0;
         idx_ff        <= '0;
         n_ff          <= '0;
         cap_ff        <= '0;
      end else begin
         fsm_ff        <= fsm_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         cnt_ff        <= cnt_in;
         bp_ff         <= bp_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
         ack_mode_ff   <= ack_mode_in;
         idx_ff        <= idx_in;
         n_ff          <= n_in;
         cap_ff        <= cap_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_dev_ff   <= key_dev_in;
      key_off_ff   <= key_off_in;
      hold_slot_ff <= hold_slot_in;
      hold_dev_ff  <= hold_dev_in;
      hold_off_ff  <= hold_off_in;
      out_ff       <= out_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bpd_ff     <= BPD_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BP_DEPTH: bpd_ff     <= csr_wdata[BPD_W-1:0];
            CSR_MAX_LEN:  max_len_ff <= csr_wdata[LEN_W-1:0];
         endcase
      end
   end

   // Result port
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {3'b000, out_ff.bp, out_ff.occ, out_ff.pend, out_ff.len,
                        out_ff.hash, out_ff.off, out_ff.dev, out_ff.slot};

   // Checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_CNT) else $error("entry count above queue depth");

   a_token_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_token)) else $error("more than one scan token");

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == FSM_IDLE) |-> !hold_valid_ff) else $error("held list entry while idle");

   a_list_cap: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == FSM_SCAN && !ack_mode_ff) |-> (n_ff < cap_ff))
      else $error("list scan past its limit");

endmodule

`default_nettype wire

### test/tb.sv
// ---------------------------------------------------------------------------
// Send queue with acknowledge tracking - block testbench
// Drives push, pop, acknowledge and list transactions with random gaps and
// response stalls, predicts every result from a local model of the queue
// and compares each response transaction field by field in arrival order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sqat_pkg::*;

   localparam int DEPTH = 32;

   // One predicted response transaction
   typedef struct {
      logic [2:0]  status;
      logic [4:0]  slot;
      logic [31:0] dev;
      logic [63:0] off;
      logic [63:0] hash;
      logic [15:0] len;
      logic        pend;
      logic [5:0]  occ;
      logic        bp;
      logic        last;
   } rsp_expect_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [CMD_W-1:0]        req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;

   send_queue_with_ack_tracking_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the queue
   logic [31:0] shadow_dev  [DEPTH];
   logic [63:0] shadow_off  [DEPTH];
   logic [63:0] shadow_hash [DEPTH];
   logic [15:0] shadow_len  [DEPTH];
   logic        shadow_pend [DEPTH];
   int          wr_ptr = 0;
   int          rd_ptr = 0;
   int          entry_cnt = 0;
   logic        bp_state = 1'b0;
   int          bp_depth = 24;
   int          max_len = 4096;

   rsp_expect_type expected_rsp[$];
   int             fail_count = 0;
   bit             rsp_quiet = 1'b0;

   initial begin
      for (int i = 0; i < DEPTH; i++) shadow_pend[i] = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void add_expect(logic [2:0] st, int slot, logic [31:0] dev,
                                      logic [63:0] off, logic [63:0] hash,
                                      logic [15:0] len, logic pend, logic last);
      rsp_expect_type e;
      e.status = st;
      e.slot   = slot[4:0];
      e.dev    = dev;
      e.off    = off;
      e.hash   = hash;
      e.len    = len;
      e.pend   = pend;
      e.occ    = entry_cnt[5:0];
      e.bp     = bp_state;
      e.last   = last;
      expected_rsp.push_back(e);
   endfunction

   // Queue behavior for one accepted request
   function automatic void predict_queue(cmd_type cmd, logic [31:0] dev, logic [63:0] off,
                                         logic [63:0] hash, logic [15:0] len,
                                         logic [5:0] lim);
      int slot;
      int n;
      int cap;
      case (cmd)
         CMD_PUSH: begin
            if (int'(len) > max_len) add_expect(STS_TOO_LARGE, 0, 0, 0, 0, 0, 0, 1);
            else if (entry_cnt >= DEPTH) add_expect(STS_FULL, 0, 0, 0, 0, 0, 0, 1);
            else begin
               slot = wr_ptr;
               shadow_dev[slot]  = dev;
               shadow_off[slot]  = off;
               shadow_hash[slot] = hash;
               shadow_len[slot]  = len;
               shadow_pend[slot] = 1'b1;
               wr_ptr = (slot + 1) % DEPTH;
               entry_cnt++;
               if (entry_cnt >= bp_depth) bp_state = 1'b1;
               add_expect(bp_state ? STS_PUSHED_BP : STS_OK, slot, 0, 0, 0, 0, 0, 1);
            end
         end
         CMD_POP: begin
            if (entry_cnt == 0) add_expect(STS_EMPTY, 0, 0, 0, 0, 0, 0, 1);
            else begin
               slot = rd_ptr;
               rd_ptr = (slot + 1) % DEPTH;
               entry_cnt--;
               if (entry_cnt < bp_depth) bp_state = 1'b0;
               add_expect(STS_OK, slot, shadow_dev[slot], shadow_off[slot],
                          shadow_hash[slot], shadow_len[slot], shadow_pend[slot], 1);
            end
         end
         CMD_ACK: begin
            slot = -1;
            for (int i = 0; i < DEPTH; i++)
               if (slot < 0 && shadow_pend[i] && shadow_dev[i] == dev && shadow_off[i] == off)
                  slot = i;
            if (slot < 0) add_expect(STS_NONE, 0, 0, 0, 0, 0, 0, 1);
            else begin
               shadow_pend[slot] = 1'b0;
               add_expect(STS_OK, slot, 0, 0, 0, 0, 0, 1);
            end
         end
         default: begin
            cap = (lim < 32) ? int'(lim) : 32;
            n = 0;
            for (int i = 0; i < DEPTH; i++)
               if (n < cap && shadow_pend[i]) begin
                  add_expect(STS_OK, i, shadow_dev[i], shadow_off[i], 0, 0, 1, 0);
                  n++;
               end
            if (n == 0) add_expect(STS_NONE, 0, 0, 0, 0, 0, 0, 1);
            else expected_rsp[$].last = 1'b1;
         end
      endcase
   endfunction

   // Send one request transaction; valid stays high into a back-to-back send
   task automatic send_item(cmd_type cmd, logic [31:0] dev, logic [63:0] off,
                            logic [63:0] hash, logic [15:0] len, logic [5:0] lim);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, lim, len, hash, off, dev};
      do @(posedge clock); while (!req_tready);
      predict_queue(cmd, dev, off, hash, len, lim);
   endtask

   // Stop sending and wait until every expected response has come
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, int value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_BP_DEPTH) bp_depth = value & 63;
      else max_len = value & 16'hFFFF;
      @(posedge clock);
   endtask

   function automatic void check_field(string name, logic [63:0] exp_val,
                                       logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
         fail_count++;
      end
   endfunction

   // Response checker and stall generator
   int stall_left = 0;
   always @(posedge clock) begin
      rsp_expect_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $error("response transaction with nothing expected");
            fail_count++;
         end else begin
            e = expected_rsp.pop_front();
            check_field("status", e.status, rsp_tuser);
            check_field("slot_index", e.slot, rsp_tdata[4:0]);
            check_field("entry_device", e.dev, rsp_tdata[36:5]);
            check_field("entry_offset", e.off, rsp_tdata[100:37]);
            check_field("entry_hash", e.hash, rsp_tdata[164:101]);
            check_field("entry_length", e.len, rsp_tdata[180:165]);
            check_field("entry_pending", e.pend, rsp_tdata[181]);
            check_field("occupancy", e.occ, rsp_tdata[187:182]);
            check_field("backpressure_flag", e.bp, rsp_tdata[188]);
            check_field("last", e.last, rsp_tlast);
         end
      end
      if ($urandom_range(0, 199) == 0) rsp_quiet = !rsp_quiet;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!rsp_quiet) stall_left = pick_gap();
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Defaults after reset, empty and no-pending cases
   task automatic test_empty_queue();
      send_item(CMD_POP, 0, 0, 0, 0, 0);
      send_item(CMD_ACK, 32'h1, 64'h2, 0, 0, 0);
      send_item(CMD_LIST, 0, 0, 0, 0, 6'd32);
   endtask

   // Field extremes and length limit at the default maximum
   task automatic test_push_extremes();
      send_item(CMD_PUSH, 32'h8000_0000, 64'h8000_0000_0000_0000, '1, 16'd0, 0);
      send_item(CMD_PUSH, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 0, 16'd4096, '1);
      send_item(CMD_PUSH, '1, '1, 64'h0123_4567_89AB_CDEF, 16'd4097, 0);
      send_item(CMD_LIST, 0, 0, 0, 0, 6'd0);
      send_item(CMD_LIST, 0, 0, 0, 0, 6'd63);
      send_item(CMD_LIST, 0, 0, 0, 0, 6'd1);
   endtask

   // Acknowledge match, repeat ack, pop of pending and cleared entries
   task automatic test_ack_pop();
      send_item(CMD_ACK, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0);
      send_item(CMD_ACK, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0);
      send_item(CMD_POP, 0, 0, 0, 0, 0);
      send_item(CMD_POP, 0, 0, 0, 0, 0);
      send_item(CMD_POP, 0, 0, 0, 0, 0);
      send_item(CMD_LIST, 0, 0, 0, 0, 6'd32);
      drain();
   endtask

   // Length register extremes and low thresholds, zero threshold included
   task automatic test_registers();
      write_csr(CSR_MAX_LEN, 65535);
      write_csr(CSR_BP_DEPTH, 1);
      send_item(CMD_PUSH, 32'h5, 64'h6, rand64(), 16'hFFFF, 0);
      send_item(CMD_POP, 0, 0, 0, 0, 0);
      drain();
      write_csr(CSR_MAX_LEN, 0);
      write_csr(CSR_BP_DEPTH, 0);
      send_item(CMD_PUSH, 32'h9, 64'hA, rand64(), 16'd1, 0);
      send_item(CMD_PUSH, 32'h9, 64'hA, rand64(), 16'd0, 0);
      send_item(CMD_POP, 0, 0, 0, 0, 0);
      send_item(CMD_POP, 0, 0, 0, 0, 0);
      drain();
   endtask

   // Fill to full, one push beyond, list every entry, then empty again
   task automatic test_full_queue();
      write_csr(CSR_MAX_LEN, 65535);
      write_csr(CSR_BP_DEPTH, 32);
      for (int i = 0; i <= DEPTH; i++)
         send_item(CMD_PUSH, $urandom, rand64(), rand64(), 16'($urandom_range(0, 65535)), 0);
      send_item(CMD_LIST, 0, 0, 0, 0, 6'd63);
      for (int i = 0; i <= DEPTH; i++) send_item(CMD_POP, 0, 0, 0, 0, 0);
      drain();
   endtask

   // Random mix of mostly well-formed traffic over several register settings
   task automatic test_random_traffic();
      int sel;
      int slot;
      int lim;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin write_csr(CSR_BP_DEPTH, 24); write_csr(CSR_MAX_LEN, 4096); end
            1: begin write_csr(CSR_BP_DEPTH, 1); write_csr(CSR_MAX_LEN, 65535); end
            2: begin
               write_csr(CSR_BP_DEPTH, $urandom_range(2, 31));
               write_csr(CSR_MAX_LEN, $urandom_range(0, 65535));
            end
            default: begin write_csr(CSR_BP_DEPTH, 32); write_csr(CSR_MAX_LEN, 1000); end
         endcase
         for (int n = 0; n < 50; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
               send_item(CMD_PUSH, $urandom, rand64(), rand64(),
                         16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, max_len)),
                         6'($urandom));
            end else if (sel < 65) begin
               send_item(CMD_POP, $urandom, rand64(), rand64(), 16'($urandom), 6'($urandom));
            end else if (sel < 85) begin
               slot = $urandom_range(0, DEPTH - 1);
               if (shadow_pend[slot] && $urandom_range(0, 4) != 0)
                  send_item(CMD_ACK, shadow_dev[slot], shadow_off[slot], rand64(),
                            16'($urandom), 6'($urandom));
               else
                  send_item(CMD_ACK, $urandom, rand64(), rand64(), 16'($urandom),
                            6'($urandom));
            end else begin
               lim = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 33);
               send_item(CMD_LIST, $urandom, rand64(), rand64(), 16'($urandom), 6'(lim));
            end
         end
         drain();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_push_extremes();
      test_ack_pop();
      test_registers();
      test_full_queue();
      test_random_traffic();
      drain();
      if (fail_count == 0) $display("send_queue_with_ack_tracking_unit test passed");
      else $display("send_queue_with_ack_tracking_unit test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("send_queue_with_ack_tracking_unit test failed");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/sqat_pkg.sv
rtl/sqat_cell.sv
rtl/send_queue_with_ack_tracking_unit.sv
test/tb.sv
